// File: hw/rtl/sssr_pkg.sv
// ----------------------------------------------------------------------------
// sssr_pkg: shared types and constants of the substring replace unit
// Request structs for the byte channels, the window cell control and the
// burst load record, plus the configuration register indexes.
// ----------------------------------------------------------------------------
package sssr_pkg;

    // Longest pattern, longest replacement, deepest result burst
    localparam int PATTERN_MAX = 8;
    localparam int REPL_MAX    = 8;
    localparam int BURST_MAX   = 8;

    // Length and count widths
    localparam int LEN_W      = 4;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT         = 3'd4;

    // Input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // Output request
    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               out_last;
        logic [COUNT_W-1:0] match_count;
        logic               truncated;
    } out_item_t;

    // Window cell control
    typedef struct packed {
        logic update;
        logic shift;
    } win_ctl_t;

    // One step's results handed to the burst chain
    typedef struct packed {
        logic [BURST_MAX*8-1:0] bytes;
        logic [LEN_W-1:0]       cnt;
        logic                   byte_valid;
        logic                   is_last;
        logic                   trunc;
        logic [COUNT_W-1:0]     mcount;
    } burst_load_t;

endpackage

// File: hw/rtl/sssr_win_cell.sv
// ----------------------------------------------------------------------------
// sssr_win_cell: one byte of the match window
// Holds a pending byte, takes the incoming byte when it lands here, compares
// against its pattern byte and shifts toward its left neighbor on a miss.
// ----------------------------------------------------------------------------
module sssr_win_cell
(
    input  logic               clk,
    input  logic [7:0]         new_byte,
    input  logic               take_new,
    input  logic [7:0]         nbr_cand,
    input  logic [7:0]         pat_byte,
    input  sssr_pkg::win_ctl_t ctl,
    output logic [7:0]         cand,
    output logic               match
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Window content after this step's write, and its compare
    always_comb
    begin
        cand      = take_new ? new_byte : byte_reg;
        match     = (cand == pat_byte);
        byte_next = ctl.shift ? nbr_cand : cand;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

// File: hw/rtl/sssr_burst.sv
// ----------------------------------------------------------------------------
// sssr_burst: result burst chain and output register
// A row of byte cells holds one step's results; while the output register
// is free or draining, the head moves into it each cycle, the rest shift down.
// ----------------------------------------------------------------------------
module sssr_burst
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  sssr_pkg::burst_load_t load_data,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sssr_pkg::out_item_t   out_data
);

    logic [7:0]                      byte_reg [sssr_pkg::BURST_MAX];
    logic [sssr_pkg::LEN_W-1:0]      cnt_reg;
    logic [sssr_pkg::LEN_W-1:0]      cnt_next;
    logic                            byte_valid_reg;
    logic                            is_last_reg;
    logic                            trunc_reg;
    logic [sssr_pkg::COUNT_W-1:0]    mcount_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    sssr_pkg::out_item_t             out_data_reg;
    sssr_pkg::out_item_t             out_data_next;
    logic                            pop;
    logic                            head_last;

    // Pop the head when the output register is free or draining
    always_comb
    begin
        pop       = (cnt_reg != '0) && (!out_valid_reg || !out_stall);
        can_load  = (cnt_reg == '0) ||
                    ((cnt_reg == sssr_pkg::LEN_W'(1)) && pop);
        head_last = is_last_reg && (cnt_reg == sssr_pkg::LEN_W'(1));

        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = load_data.cnt;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - sssr_pkg::LEN_W'(1);
        end

        out_data_next.out_byte    = byte_valid_reg ? byte_reg[0] : 8'd0;
        out_data_next.byte_valid  = byte_valid_reg;
        out_data_next.out_last    = head_last;
        out_data_next.match_count = head_last ? mcount_reg : '0;
        out_data_next.truncated   = trunc_reg;

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Burst cells and burst attributes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < sssr_pkg::BURST_MAX; i++)
            begin
                byte_reg[i] <= load_data.bytes[8*i +: 8];
            end
            byte_valid_reg <= load_data.byte_valid;
            is_last_reg    <= load_data.is_last;
            trunc_reg      <= load_data.trunc;
            mcount_reg     <= load_data.mcount;
        end
        else if (pop)
        begin
            for (int i = 0; i < sssr_pkg::BURST_MAX - 1; i++)
            begin
                byte_reg[i] <= byte_reg[i+1];
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/stream_substring_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_substring_replace_unit: streaming find-and-replace over a byte string
// Window cells match a pattern of up to 8 bytes; matches are replaced, other
// bytes are copied, and output past the per-string limit is dropped.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one input byte per request, in_last
//   marking the end of a string. out_valid/out_stall/out_data carry one
//   result byte per request; the final result of a string has out_last set
//   and the match count, and is an empty marker if no byte was left.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the registers; cfg_ready
//   is always high. Writing pattern_len starts a new string.
// Timing:
//   An accepted byte is evaluated in the cycle it is taken and its results
//   load a burst chain, whose head then moves into the output register.
//   The output port moves one result per cycle while out_stall is low; an
//   input byte that causes k results (up to 8, on a replacement or a string
//   end) holds the input until only its last result is left in the chain;
//   bytes causing at most one result flow at one per cycle while out_stall
//   is low.
// Reset: all string state clears, the burst chain empties and out_valid drops;
//   registers return to pattern_len 1, replacement_len 0, out_limit 65535.
// Stall: out_stall holds the output register; the burst chain then fills
//   and in_stall rises until results drain.
// ----------------------------------------------------------------------------
module stream_substring_replace_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  sssr_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output sssr_pkg::out_item_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sssr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sssr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PM = sssr_pkg::PATTERN_MAX;
    localparam int LW = sssr_pkg::LEN_W;
    localparam int CW = sssr_pkg::COUNT_W;

    // Configuration registers
    logic [PM*8-1:0]                  pat_bytes_reg;
    logic [LW-1:0]                    pat_len_reg;
    logic [sssr_pkg::REPL_MAX*8-1:0]  rep_bytes_reg;
    logic [LW-1:0]                    rep_len_reg;
    logic [CW-1:0]                    limit_reg;

    // String state
    logic [LW-1:0]  fill_reg;
    logic [LW-1:0]  fill_next;
    logic [CW-1:0]  emitted_reg;
    logic [CW-1:0]  emitted_next;
    logic [CW-1:0]  found_reg;
    logic [CW-1:0]  found_next;
    logic           dropped_reg;
    logic           dropped_next;

    // Step logic
    logic                   accept;
    logic                   cfg_write;
    logic                   can_load;
    logic [LW-1:0]          eff_p;
    logic [LW-1:0]          eff_r;
    logic [LW-1:0]          fill_inc;
    logic                   full;
    logic                   hit;
    logic [LW-1:0]          n_bytes;
    logic [CW-1:0]          room;
    logic [LW-1:0]          keep;
    logic                   empty_end;
    logic [PM-1:0]          pmask;
    logic [PM-1:0]          match;
    logic [7:0]             cand [PM];
    logic [PM*8-1:0]        cand_flat;
    sssr_pkg::win_ctl_t     win_ctl;
    sssr_pkg::burst_load_t  load_data;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = !can_load;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Window cell row
    for (genvar i = 0; i < PM; i++)
    begin : g_win
        logic [7:0] nbr;
        if (i == PM - 1)
        begin : g_end
            assign nbr = cand[i];
        end
        else
        begin : g_mid
            assign nbr = cand[i+1];
        end

        sssr_win_cell u_cell
        (
            .clk      (clk),
            .new_byte (in_data.in_byte),
            .take_new (fill_reg == LW'(i)),
            .nbr_cand (nbr),
            .pat_byte (pat_bytes_reg[8*i +: 8]),
            .ctl      (win_ctl),
            .cand     (cand[i]),
            .match    (match[i])
        );

        assign pmask[i]          = (LW'(i) < eff_p);
        assign cand_flat[8*i +: 8] = cand[i];
    end

    // Match decision, result count and output limit
    always_comb
    begin
        eff_p = (pat_len_reg > LW'(PM)) ? LW'(PM) : pat_len_reg;
        eff_r = (rep_len_reg > LW'(sssr_pkg::REPL_MAX)) ?
                LW'(sssr_pkg::REPL_MAX) : rep_len_reg;

        fill_inc = fill_reg + LW'(1);
        full     = (eff_p != '0) && (fill_inc == eff_p);
        hit      = full && (&(match | ~pmask));

        if (eff_p == '0)
        begin
            n_bytes   = LW'(1);
            fill_next = fill_reg;
        end
        else if (hit)
        begin
            n_bytes   = eff_r;
            fill_next = '0;
        end
        else if (full)
        begin
            n_bytes   = in_data.in_last ? eff_p : LW'(1);
            fill_next = in_data.in_last ? '0 : (eff_p - LW'(1));
        end
        else
        begin
            n_bytes   = in_data.in_last ? fill_inc : '0;
            fill_next = in_data.in_last ? '0 : fill_inc;
        end

        win_ctl.update = accept && (eff_p != '0);
        win_ctl.shift  = full && !hit;

        // no room left once the limit is reached or lowered below the count
        room = (emitted_reg >= limit_reg) ? '0 : (limit_reg - emitted_reg);
        keep = (CW'(n_bytes) > room) ? LW'(room) : n_bytes;

        emitted_next = emitted_reg + CW'(keep);
        dropped_next = dropped_reg || (n_bytes != keep);
        found_next   = (hit && (found_reg != {CW{1'b1}})) ? found_reg + CW'(1) : found_reg;

        empty_end = in_data.in_last && (keep == '0);

        load_data.bytes      = hit ? rep_bytes_reg : cand_flat;
        load_data.cnt        = empty_end ? LW'(1) : keep;
        load_data.byte_valid = !empty_end;
        load_data.is_last    = in_data.in_last;
        load_data.trunc      = dropped_next;
        load_data.mcount     = found_next;
    end

    // Configuration and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LW'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            limit_reg     <= {CW{1'b1}};
            fill_reg      <= '0;
            emitted_reg   <= '0;
            found_reg     <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (in_data.in_last)
                begin
                    fill_reg    <= '0;
                    emitted_reg <= '0;
                    found_reg   <= '0;
                    dropped_reg <= 1'b0;
                end
                else
                begin
                    fill_reg    <= fill_next;
                    emitted_reg <= emitted_next;
                    found_reg   <= found_next;
                    dropped_reg <= dropped_next;
                end
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    sssr_pkg::CFG_PATTERN_BYTES:
                    begin
                        pat_bytes_reg <= cfg_data[PM*8-1:0];
                    end
                    sssr_pkg::CFG_PATTERN_LEN:
                    begin
                        // new pattern length starts a new string
                        pat_len_reg <= cfg_data[LW-1:0];
                        fill_reg    <= '0;
                        emitted_reg <= '0;
                        found_reg   <= '0;
                        dropped_reg <= 1'b0;
                    end
                    sssr_pkg::CFG_REPLACEMENT_BYTES:
                    begin
                        rep_bytes_reg <= cfg_data[sssr_pkg::REPL_MAX*8-1:0];
                    end
                    sssr_pkg::CFG_REPLACEMENT_LEN:
                    begin
                        rep_len_reg <= cfg_data[LW-1:0];
                    end
                    sssr_pkg::CFG_OUT_LIMIT:
                    begin
                        limit_reg <= cfg_data[CW-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result burst and output register
    sssr_burst u_burst
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (load_data),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stream_substring_replace_unit
// Feeds byte strings under many pattern, replacement and limit settings,
// predicts every result request in a cycle-free model of the find-and-replace
// and compares each accepted result field by field. Both ports idle at random,
// and one long output hold-off backs the unit up into its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned RANDOM_PHASES  = 12;
    localparam int unsigned PHASE_BYTES    = 34;
    localparam int unsigned HOLD_CYCLES    = 120;
    localparam int unsigned HOLD_AFTER     = 150;
    localparam int unsigned IDLE_PCT       = 31;

    // Index beyond the register list, written to check it is ignored
    localparam logic [sssr_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    sssr_pkg::in_item_t               in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    sssr_pkg::out_item_t              out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [sssr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [sssr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Stimulus and expectation stores
    sssr_pkg::in_item_t    text_to_send [$];
    sssr_pkg::out_item_t   predicted_out [$];
    int unsigned reqs_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    logic        req_taken = 1'b0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic [7:0]  alphabet [3];

    // Register copies
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] rep_bytes;
    logic [3:0]  rep_len;
    logic [15:0] out_lim;

    // Per-string state
    logic [7:0]  win [sssr_pkg::PATTERN_MAX];
    int unsigned win_fill;
    int unsigned emitted;
    logic [15:0] found;
    logic        dropped;
    logic [7:0]  step_bytes [$];

    wire calm = (reqs_accepted >= 300) && (reqs_accepted < 380);

    stream_substring_replace_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_len(logic [3:0] v);
        return (v > sssr_pkg::PATTERN_MAX) ? sssr_pkg::PATTERN_MAX : int'(v);
    endfunction

    function automatic void clear_string();
        foreach (win[i])
            win[i] = '0;
        win_fill = 0;
        emitted  = 0;
        found    = '0;
        dropped  = 1'b0;
    endfunction

    function automatic void reset_regs();
        pat_bytes = '0;
        pat_len   = 4'd1;
        rep_bytes = '0;
        rep_len   = 4'd0;
        out_lim   = 16'hFFFF;
        clear_string();
    endfunction

    function automatic void apply_reg(logic [sssr_pkg::CFG_IDX_W-1:0] idx,
                                      logic [sssr_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            sssr_pkg::CFG_PATTERN_BYTES:     pat_bytes = val;
            sssr_pkg::CFG_PATTERN_LEN:
            begin
                pat_len = val[3:0];
                clear_string();
            end
            sssr_pkg::CFG_REPLACEMENT_BYTES: rep_bytes = val;
            sssr_pkg::CFG_REPLACEMENT_LEN:   rep_len = val[3:0];
            sssr_pkg::CFG_OUT_LIMIT:         out_lim = val[15:0];
            default: ;
        endcase
    endfunction

    // Emit one byte unless the per-string limit is used up
    function automatic void emit_byte(logic [7:0] b);
        if (emitted < out_lim && step_bytes.size() < 16)
        begin
            step_bytes.push_back(b);
            emitted++;
        end
        else
            dropped = 1'b1;
    endfunction

    // One input request in, its result requests onto predicted_out
    function automatic void replace_step(sssr_pkg::in_item_t req);
        int unsigned plen;
        int unsigned rlen;
        logic        hit;
        sssr_pkg::out_item_t   res [$];
        sssr_pkg::out_item_t   r;

        plen = clamp_len(pat_len);
        rlen = clamp_len(rep_len);
        step_bytes.delete();
        if (plen == 0)
            emit_byte(req.in_byte);
        else
        begin
            if (win_fill >= plen)
                win_fill = plen - 1;
            win[win_fill] = req.in_byte;
            win_fill++;
            if (win_fill == plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (win[i] != pat_bytes[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                        emit_byte(rep_bytes[8*i +: 8]);
                    if (found != 16'hFFFF)
                        found++;
                    win_fill = 0;
                end
                else
                begin
                    emit_byte(win[0]);
                    for (int i = 1; i < plen; i++)
                        win[i-1] = win[i];
                    win_fill--;
                end
            end
            // flush what is still undecided
            if (req.in_last)
            begin
                for (int i = 0; i < win_fill; i++)
                    emit_byte(win[i]);
                win_fill = 0;
            end
        end

        foreach (step_bytes[i])
        begin
            r = '{out_byte: step_bytes[i], byte_valid: 1'b1, out_last: 1'b0,
                  match_count: '0, truncated: dropped};
            res.push_back(r);
        end
        if (req.in_last)
        begin
            // empty end marker when nothing is left to send
            if (res.size() == 0)
            begin
                r = '0;
                res.push_back(r);
            end
            res[res.size()-1].out_last    = 1'b1;
            res[res.size()-1].match_count = found;
            res[res.size()-1].truncated   = dropped;
            clear_string();
        end
        foreach (res[i])
            predicted_out.push_back(res[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: offers queued bytes, holds a request until it is taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !req_taken))
        begin
            if (text_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                in_data  <= text_to_send.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Accepted input requests go through the predictor
    always @(posedge clk)
    begin
        req_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            replace_step(in_data);
            reqs_accepted++;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stall plus one long hold-off while input is queued
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && reqs_accepted >= HOLD_AFTER && text_to_send.size() > 20)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Output monitor
    always @(posedge clk)
    begin
        sssr_pkg::out_item_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_out.size() == 0)
            begin
                $display("%0t: unexpected result, expected none got %p", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = predicted_out.pop_front();
                check_field("out_byte",    16'(want.out_byte),   16'(out_data.out_byte));
                check_field("byte_valid",  16'(want.byte_valid), 16'(out_data.byte_valid));
                check_field("out_last",    16'(want.out_last),   16'(out_data.out_last));
                check_field("match_count", want.match_count,     out_data.match_count);
                check_field("truncated",   16'(want.truncated),  16'(out_data.truncated));
            end
        end
    end

    // Watchdog on cycles without any request moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [sssr_pkg::CFG_IDX_W-1:0] idx,
                             logic [sssr_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until everything sent has come back and the unit has settled
    task automatic wait_drained();
        while (text_to_send.size() != 0 || in_valid || predicted_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic void add_req(logic [7:0] b, logic last);
        sssr_pkg::in_item_t req;

        req.in_byte = b;
        req.in_last = last;
        text_to_send.push_back(req);
    endfunction

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 99) < 85)
            return alphabet[$urandom_range(0, 2)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Random strings built from pattern pieces and alphabet symbols
    task automatic queue_text(int unsigned goal, logic open_end);
        logic [7:0]  txt [$];
        int unsigned made;
        int unsigned len;
        int unsigned plen;
        int unsigned m;

        made = 0;
        plen = clamp_len(pat_len);
        while (made < goal)
        begin
            txt.delete();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            while (txt.size() < len)
            begin
                if (plen != 0 && $urandom_range(0, 1) == 1)
                begin
                    m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
                    for (int k = 0; k < m; k++)
                        txt.push_back(pat_bytes[8*k +: 8]);
                end
                else
                    txt.push_back(pick_symbol());
            end
            made += txt.size();
            foreach (txt[k])
                add_req(txt[k], (k == txt.size() - 1) && !(open_end && made >= goal));
        end
    endtask

    // Register settings for one random phase; the first four hit the extremes
    task automatic random_setup(int unsigned ph);
        logic [3:0]                      plen_tab [4] = '{4'd1, 4'd8, 4'd15, 4'd0};
        logic [3:0]                      rlen_tab [4] = '{4'd8, 4'd0, 4'd12, 4'd1};
        logic [15:0]                     lim_tab  [4] = '{16'hFFFF, 16'd0, 16'd7, 16'hFFFF};
        logic [3:0]                      plen;
        logic [3:0]                      rlen;
        logic [15:0]                     lim;
        logic [sssr_pkg::CFG_DATA_W-1:0] val;

        foreach (alphabet[i])
            alphabet[i] = 8'($urandom_range(0, 255));
        if (ph < 4)
        begin
            plen = plen_tab[ph];
            rlen = rlen_tab[ph];
            lim  = lim_tab[ph];
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       plen = 4'd0;
                1:       plen = 4'($urandom_range(9, 15));
                default: plen = 4'($urandom_range(1, 8));
            endcase
            rlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            case ($urandom_range(0, 3))
                0:       lim = 16'hFFFF;
                1:       lim = 16'($urandom_range(0, 8));
                2:       lim = 16'($urandom_range(0, 65535));
                default: lim = 16'($urandom_range(9, 40));
            endcase
        end

        val = {$urandom, $urandom};
        for (int k = 0; k < sssr_pkg::PATTERN_MAX; k++)
            val[8*k +: 8] = alphabet[$urandom_range(0, 2)];
        write_reg(sssr_pkg::CFG_PATTERN_BYTES, val);
        val = {$urandom, $urandom};
        val[3:0] = plen;
        write_reg(sssr_pkg::CFG_PATTERN_LEN, val);
        write_reg(sssr_pkg::CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
        val = {$urandom, $urandom};
        val[3:0] = rlen;
        write_reg(sssr_pkg::CFG_REPLACEMENT_LEN, val);
        val = {$urandom, $urandom};
        val[15:0] = lim;
        write_reg(sssr_pkg::CFG_OUT_LIMIT, val);
        if ($urandom_range(0, 3) == 0)
            write_reg(sssr_pkg::CFG_IDX_W'($urandom_range(int'(sssr_pkg::CFG_OUT_LIMIT) + 1,
                                                          int'(CFG_IDX_TOP))),
                      {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_regs();
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // Reset settings: zero bytes are deleted; last byte deleted gives the empty marker
        add_req(8'h00, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(8'h00, 1'b1);
        add_req(8'h00, 1'b1);
        wait_drained();

        // "ab" -> "XYZ": plain match, overlap, then an open string
        write_reg(sssr_pkg::CFG_PATTERN_BYTES, 64'h6261);
        write_reg(sssr_pkg::CFG_PATTERN_LEN, 64'd2);
        write_reg(sssr_pkg::CFG_REPLACEMENT_BYTES, 64'h5A5958);
        write_reg(sssr_pkg::CFG_REPLACEMENT_LEN, 64'd3);
        add_req(8'h78, 1'b0);
        add_req(8'h61, 1'b0);
        add_req(8'h62, 1'b0);
        add_req(8'h61, 1'b0);
        add_req(8'h62, 1'b1);
        add_req(8'h61, 1'b0);
        add_req(8'h61, 1'b0);
        add_req(8'h62, 1'b1);
        add_req(8'h61, 1'b0);
        wait_drained();

        // Length change drops the pending byte; widest pattern and replacement
        write_reg(sssr_pkg::CFG_PATTERN_BYTES, '1);
        write_reg(sssr_pkg::CFG_PATTERN_LEN, 64'd8);
        write_reg(sssr_pkg::CFG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(sssr_pkg::CFG_REPLACEMENT_LEN, 64'd8);
        for (int k = 0; k < sssr_pkg::PATTERN_MAX; k++)
            add_req(8'hFF, k == sssr_pkg::PATTERN_MAX - 1);
        wait_drained();

        // Zero pattern length passes bytes straight through; limit of one truncates
        write_reg(sssr_pkg::CFG_PATTERN_LEN, 64'd0);
        write_reg(sssr_pkg::CFG_OUT_LIMIT, 64'd1);
        write_reg(CFG_IDX_TOP, '1);
        add_req(8'h5A, 1'b0);
        add_req(8'hA5, 1'b1);
        wait_drained();

        // Random phases, mostly closed strings, sometimes left open
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_setup(ph);
            queue_text(PHASE_BYTES, $urandom_range(0, 3) == 0);
            wait_drained();
        end

        if (mismatches == 0 && predicted_out.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: stream_substring_replace_unit.f
hw/rtl/sssr_pkg.sv
hw/rtl/sssr_win_cell.sv
hw/rtl/sssr_burst.sv
hw/rtl/stream_substring_replace_unit.sv
sim/testbench.sv
